// ----- design/jse_pkg.sv -----
`default_nettype none

package jse_pkg;

    localparam int CntW = 17;
    localparam int ByteW = 8;
    localparam logic [CntW-1:0] BufReset = 17'd4096;

    localparam logic [ByteW-1:0] ChBslash = 8'h5C;
    localparam logic [ByteW-1:0] ChQuote  = 8'h22;
    localparam logic [ByteW-1:0] ChLf     = 8'h0A;
    localparam logic [ByteW-1:0] ChCr     = 8'h0D;
    localparam logic [ByteW-1:0] ChTab    = 8'h09;
    localparam logic [ByteW-1:0] ChN      = 8'h6E;
    localparam logic [ByteW-1:0] ChR      = 8'h72;
    localparam logic [ByteW-1:0] ChT      = 8'h74;
    localparam logic [ByteW-1:0] ChU      = 8'h75;
    localparam logic [ByteW-1:0] ChZero   = 8'h30;
    localparam logic [ByteW-1:0] CtlLimit = 8'h20;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_PAIR = 2'd1,
        KIND_UNI  = 2'd2,
        KIND_OVF  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [ByteW-1:0] data;
        logic             eos;
    } t_cmd;

    function automatic t_kind classify(input logic [ByteW-1:0] b);
        t_kind k;
        k = KIND_PASS;
        if (b == ChQuote || b == ChBslash || b == ChLf || b == ChCr || b == ChTab) begin
            k = KIND_PAIR;
        end else if (b < CtlLimit) begin
            k = KIND_UNI;
        end
        return k;
    endfunction

    function automatic logic [2:0] run_len(input t_kind k);
        logic [2:0] n;
        case (k)
            KIND_PAIR: n = 3'd2;
            KIND_UNI:  n = 3'd6;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] v);
        logic [ByteW-1:0] c;
        if (v < 4'd10) begin
            c = {4'h3, v};
        end else begin
            c = 8'h57 + {4'h0, v};
        end
        return c;
    endfunction

    function automatic logic [ByteW-1:0] pair_char(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] c;
        case (b)
            ChLf:    c = ChN;
            ChCr:    c = ChR;
            ChTab:   c = ChT;
            default: c = b;
        endcase
        return c;
    endfunction

    // byte at position idx of the escaped run
    function automatic logic [ByteW-1:0] esc_byte(input t_kind k, input logic [ByteW-1:0] b,
                                                  input logic [2:0] idx);
        logic [ByteW-1:0] c;
        c = '0;
        case (k)
            KIND_PASS: c = b;
            KIND_PAIR: c = (idx == 3'd0) ? ChBslash : pair_char(b);
            KIND_UNI: begin
                case (idx)
                    3'd0:    c = ChBslash;
                    3'd1:    c = ChU;
                    3'd4:    c = hex_digit(b[7:4]);
                    3'd5:    c = hex_digit(b[3:0]);
                    default: c = ChZero;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/jse_front.sv -----
`default_nettype none

module jse_front #(
    parameter int MAX_BUFFER = 65536
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [7:0]                i_byte,
    input  wire logic                      i_eos,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [16:0]               i_cfg_wr_data,
    input  wire logic                      i_q_full,
    output logic                           o_full,
    output logic                           o_q_push,
    output jse_pkg::t_cmd                  o_q_cmd
);
    import jse_pkg::*;

    localparam logic [CntW-1:0] MaxBuf = CntW'(MAX_BUFFER);

    logic [CntW-1:0] r_buf_size, n_buf_size;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;

    logic            accept;
    t_kind           kind;
    logic [CntW:0]   sum;
    logic            no_room;

    assign o_full  = i_q_full;
    assign accept  = i_push && !i_q_full;
    assign kind    = classify(i_byte);
    assign sum     = {1'b0, r_cnt} + (CntW+1)'(run_len(kind));
    assign no_room = sum >= {1'b0, r_buf_size};

    always_comb begin
        n_buf_size = r_buf_size;
        if (i_cfg_wr_en) begin
            n_buf_size = (i_cfg_wr_data > MaxBuf) ? MaxBuf : i_cfg_wr_data;
        end
    end

    always_comb begin
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        o_q_push     = 1'b0;
        o_q_cmd.kind = no_room ? KIND_OVF : kind;
        o_q_cmd.data = i_byte;
        o_q_cmd.eos  = i_eos;
        if (accept) begin
            if (r_ovf) begin
                // rest of an overflowed string is dropped
                if (i_eos) begin
                    n_ovf = 1'b0;
                    n_cnt = '0;
                end
            end else begin
                o_q_push = 1'b1;
                if (i_eos) begin
                    n_cnt = '0;
                end else if (no_room) begin
                    n_ovf = 1'b1;
                end else begin
                    n_cnt = sum[CntW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= BufReset;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_buf_size <= n_buf_size;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_eos) |=> (r_cnt == '0 && !r_ovf))
        else $error("string state not cleared at end of string");

endmodule

`default_nettype wire

// ----- design/jse_fifo.sv -----
`default_nettype none

module jse_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire jse_pkg::t_cmd   i_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output jse_pkg::t_cmd        o_head
);
    import jse_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntQW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntQW-1:0] FullCnt = CntQW'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntQW-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- design/jse_back.sv -----
`default_nettype none

module jse_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire jse_pkg::t_cmd   i_q_head,
    input  wire logic            i_pop,
    output logic                 o_q_pop,
    output logic                 o_empty,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_last,
    output logic                 o_string_last,
    output logic                 o_overflow
);
    import jse_pkg::*;

    logic [2:0]  r_idx, n_idx;
    logic        r_vld;
    logic [7:0]  r_byte;
    logic        r_run_last, r_str_last, r_ovf;

    logic        load, emit, last;
    logic [2:0]  len;

    assign load    = !r_vld || i_pop;
    assign emit    = load && !i_q_empty;
    assign len     = run_len(i_q_head.kind);
    assign last    = (r_idx == len - 3'd1);
    assign o_q_pop = emit && last;

    always_comb begin
        n_idx = r_idx;
        if (emit) begin
            n_idx = last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_vld <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_vld <= !i_q_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte     <= esc_byte(i_q_head.kind, i_q_head.data, r_idx);
            r_run_last <= last;
            r_str_last <= last && i_q_head.eos;
            r_ovf      <= (i_q_head.kind == KIND_OVF);
        end
    end

    assign o_empty       = !r_vld;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_str_last;
    assign o_overflow    = r_ovf;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd5)
        else $error("run position out of range");

    // mid-run the command must still sit at the queue head
    a_mid_run_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> !i_q_empty)
        else $error("queue drained during a run");

    a_ovf_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && i_q_head.kind == KIND_OVF) |-> o_q_pop)
        else $error("overflow item not a single result");

endmodule

`default_nettype wire

// ----- design/json_string_escaper_top.sv -----
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------------
// input     | push / full         | i_in_byte, i_end_of_string
// result    | empty / pop         | o_out_byte, o_run_last, o_string_last, o_overflow
// config    | i_cfg_wr_en         | i_cfg_wr_data (buffer size, saturates)
//
// the back end delivers one result per cycle while pop is high and the queue holds items:
// an item gives 1, 2 or 6 results (run length); one that gives none is dropped at the front
// an accepted item is written to the queue; its results then pass the output register
// full follows the front/back queue, so input stalls only when QUEUE_DEPTH items wait
// synchronous active-low reset clears counts, queue and output valid; buffer size returns to 4096
`default_nettype none

module json_string_escaper_top #(
    parameter int MAX_BUFFER  = 65536,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_string,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_string_last,
    output logic             o_overflow,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [16:0] i_cfg_wr_data
);
    import jse_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    t_cmd q_cmd, q_head;

    jse_front #(
        .MAX_BUFFER(MAX_BUFFER)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_byte       (i_in_byte),
        .i_eos        (i_end_of_string),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_q_full     (q_full),
        .o_full       (full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_cmd)
    );

    jse_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    jse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .i_pop        (pop),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_last(o_string_last),
        .o_overflow   (o_overflow)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb;

    import jse_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int HoldCycles  = 300;
    localparam int SettleDelay = 10;
    localparam int MaxBufSize  = 65536;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChPlainA = 8'h41;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_last;
        logic       overflow;
    } t_escaped;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_end_of_string;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_string_last;
    logic        o_overflow;
    logic        i_cfg_wr_en;
    logic [16:0] i_cfg_wr_data;

    // model state of the escaper
    int       model_buf_size;
    int       model_count;
    bit       model_in_error;
    t_escaped escaped_q[$];

    int mismatch_count;
    int cycle_count;
    bit idle_on;
    bit hold_req;

    json_string_escaper_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_string_last   (o_string_last),
        .o_overflow      (o_overflow),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // works out the escaped run of one accepted item
    task automatic predict_escape(input logic [7:0] b, input logic eos);
        logic [7:0] seq [6];
        int n;
        t_escaped r;
        if (model_in_error) begin
            if (eos) begin
                model_in_error = 1'b0;
                model_count = 0;
            end
            return;
        end
        n = 1;
        seq[0] = b;
        if (b == ChQuote || b == ChBslash) begin
            n = 2;
            seq[0] = ChBslash;
            seq[1] = b;
        end else if (b == ChLf || b == ChCr || b == ChTab) begin
            n = 2;
            seq[0] = ChBslash;
            seq[1] = (b == ChLf) ? ChN : (b == ChCr) ? ChR : ChT;
        end else if (b < 8'h20) begin
            n = 6;
            seq[0] = ChBslash;
            seq[1] = ChU;
            seq[2] = ChZero;
            seq[3] = ChZero;
            seq[4] = ChZero + {7'd0, b[4]};
            seq[5] = (b[3:0] < 4'd10) ? ChZero + {4'd0, b[3:0]}
                                       : ChLowerA + {4'd0, b[3:0]} - 8'd10;
        end
        if (model_count + n >= model_buf_size) begin
            r = '{data: 8'h00, run_last: 1'b1, string_last: eos, overflow: 1'b1};
            escaped_q.push_back(r);
            if (eos) model_count = 0;
            else     model_in_error = 1'b1;
        end else begin
            for (int k = 0; k < n; k++) begin
                r = '{data: seq[k], run_last: (k == n - 1),
                      string_last: (k == n - 1) && eos, overflow: 1'b0};
                escaped_q.push_back(r);
            end
            model_count = eos ? 0 : model_count + n;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic eos);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        predict_escape(b, eos);
    endtask

    // only while idle: drain results, let items that give none go through
    task automatic set_buffer_size(input logic [16:0] v);
        push <= 1'b0;
        @(posedge i_clk);
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (SettleDelay) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_buf_size = (int'(v) > MaxBufSize) ? MaxBufSize : int'(v);
    endtask

    function automatic logic [7:0] random_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2: b = 8'($urandom_range(0, 31));
            3: begin
                case ($urandom_range(0, 4))
                    0: b = ChQuote;
                    1: b = ChBslash;
                    2: b = ChLf;
                    3: b = ChCr;
                    default: b = ChTab;
                endcase
            end
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic logic [16:0] random_buffer_size();
        logic [16:0] v;
        case ($urandom_range(0, 9))
            0: v = 17'($urandom_range(0, 1));
            1: v = 17'(MaxBufSize);
            2: v = 17'($urandom_range(0, 131071));
            3: v = 17'd4096;
            default: v = 17'($urandom_range(2, 40));
        endcase
        return v;
    endfunction

    // every escape class at the reset buffer size
    task automatic test_escape_classes();
        logic [7:0] bytes [13];
        bytes = '{ChQuote, ChBslash, ChLf, ChCr, ChTab, 8'h00, 8'h01, 8'h1F,
                  8'h20, ChPlainA, 8'h7F, 8'h80, 8'hFF};
        for (int k = 0; k < 13; k++) send_item(bytes[k], k == 12);
    endtask

    task automatic test_overflow();
        set_buffer_size(17'd2);
        send_item(ChPlainA, 1'b0);
        // overflow mid-string, rest of string swallowed until end
        send_item(ChPlainA + 8'd1, 1'b0);
        send_item(ChPlainA + 8'd2, 1'b0);
        send_item(ChPlainA + 8'd3, 1'b1);
        send_item(ChPlainA + 8'd4, 1'b1);
        set_buffer_size(17'd8);
        send_item(ChLf, 1'b0);
        // overflow on the last byte of the string
        send_item(8'h01, 1'b1);
        send_item(ChPlainA, 1'b1);
    endtask

    task automatic test_config_extremes();
        set_buffer_size(17'h1FFFF);
        send_item(8'h1E, 1'b1);
        set_buffer_size(17'd0);
        send_item(ChPlainA, 1'b1);
        set_buffer_size(17'd1);
        send_item(ChPlainA, 1'b0);
        send_item(ChPlainA, 1'b1);
        set_buffer_size(17'(MaxBufSize));
        send_item(8'hC3, 1'b1);
    endtask

    // results held back long enough for the input side to stall
    task automatic test_backpressure();
        set_buffer_size(17'd4096);
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) send_item(ChPlainA + 8'(k), k == 11);
    endtask

    task automatic test_random_strings();
        int sent;
        int len;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 6) idle_on = 1'b0;
            set_buffer_size(random_buffer_size());
            sent = 0;
            while (sent < 12) begin
                len = $urandom_range(1, 12);
                // now and then a string is cut short
                for (int k = 0; k < len; k++)
                    send_item(random_byte(), k == len - 1 || $urandom_range(0, 30) == 0);
                sent += len;
            end
        end
    endtask

    // result side: random stalls plus one long hold
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_escaped exp_r;
        if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
            if (escaped_q.size() == 0) begin
                $display("%0t: unexpected result byte %h", $time, o_out_byte);
                mismatch_count++;
            end else begin
                exp_r = escaped_q.pop_front();
                if (o_out_byte !== exp_r.data) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, exp_r.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_run_last !== exp_r.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, exp_r.run_last, o_run_last);
                    mismatch_count++;
                end
                if (o_string_last !== exp_r.string_last) begin
                    $display("%0t: string_last expected %b actual %b",
                             $time, exp_r.string_last, o_string_last);
                    mismatch_count++;
                end
                if (o_overflow !== exp_r.overflow) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_r.overflow, o_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        push <= 1'b0;
        i_in_byte <= 8'h00;
        i_end_of_string <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        i_rst_n <= 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        model_buf_size = int'(BufReset);
        model_count = 0;
        model_in_error = 1'b0;
        idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_escape_classes();
        test_overflow();
        test_config_extremes();
        test_backpressure();
        test_random_strings();

        push <= 1'b0;
        @(posedge i_clk);
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (SettleDelay) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
